// File: hdl/ttp_pkg.sv
// Package for the touch-to-pointer translator: command/result types, codes and
// the packing widths of the stream ports. No dependencies.
package ttp_pkg;

  localparam int unsigned IN_TDATA_W  = 128;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  // raw command codes on the input tuser
  localparam logic [CMD_W-1:0] CMD_RESET = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DOWN  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MOVE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UP    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SEC   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_MOUSE = 3'd5;
  localparam logic [CMD_W-1:0] CMD_FRAME = 3'd6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEFT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT = 1'b1;

  // result kinds
  localparam logic KIND_PTR   = 1'b0;
  localparam logic KIND_WHEEL = 1'b1;

  typedef enum logic [2:0] {
    OP_RESET, OP_DOWN, OP_MOVE, OP_UP, OP_SEC, OP_MOUSE, OP_FRAME
  } ttp_op_e;

  typedef struct packed {
    ttp_op_e     op;
    logic [63:0] tag;
    logic [15:0] x;
    logic [15:0] y;
    logic        inb;
    logic [7:0]  mbtn;
    logic [7:0]  wx;
    logic [7:0]  wy;
  } ttp_cmd_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  btn;
    logic [7:0]  wx;
    logic [7:0]  wy;
  } ttp_res_t;

  // queue status seen by the back end
  typedef struct packed {
    logic     empty;
    ttp_cmd_t head;
  } ttp_q_stat_t;

  function automatic ttp_res_t ptr_res(logic [15:0] x, logic [15:0] y, logic [7:0] b);
    ttp_res_t r;
    r.kind = KIND_PTR;
    r.x    = x;
    r.y    = y;
    r.btn  = b;
    r.wx   = 8'd0;
    r.wy   = 8'd0;
    return r;
  endfunction

  function automatic ttp_res_t wheel_res(logic [7:0] wx, logic [7:0] wy);
    ttp_res_t r;
    r.kind = KIND_WHEEL;
    r.x    = 16'd0;
    r.y    = 16'd0;
    r.btn  = 8'd0;
    r.wx   = wx;
    r.wy   = wy;
    return r;
  endfunction

endpackage

// File: hdl/touch_to_pointer_translator_core.sv
// Top level of the touch-to-pointer translator: front end, command queue, back end.
// Depends on ttp_pkg, ttp_front, ttp_queue, ttp_back.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+-------------------------------------
//   s_axis   | in        | tvalid/tready         | tuser command, tdata event fields
//   m_axis   | out       | tvalid/tready, tlast  | tuser kind, tdata pointer/wheel
//   cfg      | in        | cfg_we_i, no wait     | 1-bit index, 8-bit button code
//
// In the back end an event is dequeued with its tag lookup, then applied, then goes
// through the two pick states on the single slot read port when the pointer is
// recomputed, and the emit state moves each result into the output register once it is free.
// The front end keeps accepting into a two-entry queue while the back end works.
// A held output transfer stalls only the back end; the queue then fills.
// Reset is asynchronous: touch table empty, pointer at zero, masks 1 and 2.
module touch_to_pointer_translator_core
  import ttp_pkg::*;
#(
  parameter int unsigned MAX_TOUCHES = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // event stream
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // finger_tag[63:0], pos_x[79:64],
                                                  // pos_y[95:80], in_bounds[96],
                                                  // mouse_buttons[104:97],
                                                  // scroll_x[112:105], scroll_y[120:113]
  input  logic [CMD_W-1:0]       s_axis_tuser_i,  // command
  // pointer action stream
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,  // out_x[15:0], out_y[31:16],
                                                  // out_buttons[39:32],
                                                  // out_wheel_x[47:40], out_wheel_y[55:48]
  output logic                   m_axis_tuser_o,  // action_kind
  output logic                   m_axis_tlast_o   // last_of_run
);

  logic        q_full, q_push, q_pop;
  ttp_cmd_t    q_cmd;
  ttp_q_stat_t q_stat;
  ttp_res_t    res;

  ttp_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_full_i        (q_full),
    .push_o          (q_push),
    .cmd_o           (q_cmd)
  );

  ttp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (q_cmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .stat_o (q_stat)
  );

  ttp_back #(
    .MAX_TOUCHES (MAX_TOUCHES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .q_stat_i    (q_stat),
    .q_pop_o     (q_pop),
    .res_o       (res),
    .res_last_o  (m_axis_tlast_o),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {res.wy, res.wx, res.btn, res.y, res.x};
  assign m_axis_tuser_o = res.kind;

endmodule

// File: hdl/ttp_front.sv
// Front end: accepts input transfers, unpacks and classifies them into commands.
// Depends on ttp_pkg.
module ttp_front
  import ttp_pkg::*;
(
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata_i,  // tag, pos_x, pos_y, in_bounds, buttons, scroll_x, scroll_y
  input  logic [CMD_W-1:0]      s_axis_tuser_i,  // command
  input  logic                  q_full_i,
  output logic                  push_o,
  output ttp_cmd_t              cmd_o
);

  logic keep;

  always_comb begin
    cmd_o.tag  = s_axis_tdata_i[63:0];
    cmd_o.x    = s_axis_tdata_i[79:64];
    cmd_o.y    = s_axis_tdata_i[95:80];
    cmd_o.inb  = s_axis_tdata_i[96];
    cmd_o.mbtn = s_axis_tdata_i[104:97];
    cmd_o.wx   = s_axis_tdata_i[112:105];
    cmd_o.wy   = s_axis_tdata_i[120:113];
    cmd_o.op   = OP_RESET;
    keep       = 1'b1;
    unique case (s_axis_tuser_i)
      CMD_RESET: cmd_o.op = OP_RESET;
      CMD_DOWN: begin
        // a touch outside the screen has no effect at all
        cmd_o.op = OP_DOWN;
        keep     = s_axis_tdata_i[96];
      end
      CMD_MOVE:  cmd_o.op = OP_MOVE;
      CMD_UP:    cmd_o.op = OP_UP;
      CMD_SEC:   cmd_o.op = OP_SEC;
      CMD_MOUSE: cmd_o.op = OP_MOUSE;
      CMD_FRAME: cmd_o.op = OP_FRAME;
      default:   keep = 1'b0;
    endcase
  end

  assign s_axis_tready_o = ~q_full_i;
  assign push_o          = s_axis_tvalid_i & ~q_full_i & keep;

endmodule

// File: hdl/ttp_queue.sv
// Short command queue between front and back end, flip-flop storage.
// Depends on ttp_pkg.
module ttp_queue
  import ttp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  ttp_cmd_t    cmd_i,
  output logic        full_o,
  input  logic        pop_i,
  output ttp_q_stat_t stat_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  ttp_cmd_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) wr_ptr_d = wr_ptr_q + PtrW'(1);
    if (pop_i)  rd_ptr_d = rd_ptr_q + PtrW'(1);
    if (push_i && !pop_i) cnt_d = cnt_q + CntW'(1);
    if (!push_i && pop_i) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= cmd_i;
  end

  assign full_o       = (cnt_q == CntW'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.head  = mem_q[rd_ptr_q];

endmodule

// File: hdl/ttp_back.sv
// Back end: touch table, pointer state and result sequencer with output register.
// Depends on ttp_pkg.
module ttp_back
  import ttp_pkg::*;
#(
  parameter int unsigned MAX_TOUCHES = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  ttp_q_stat_t           q_stat_i,
  output logic                  q_pop_o,
  output ttp_res_t              res_o,
  output logic                  res_last_o,
  output logic                  res_valid_o,
  input  logic                  res_ready_i
);

  localparam int unsigned IdxW = $clog2(MAX_TOUCHES);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_APPLY  = 3'd1;
  localparam logic [2:0] ST_PICK_A = 3'd2;
  localparam logic [2:0] ST_PICK_B = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  // config
  logic [7:0] left_q, right_q;

  // touch table
  logic [MAX_TOUCHES-1:0] used_q, used_d;
  logic [63:0]            tag_q [MAX_TOUCHES];
  logic [15:0]            sx_q  [MAX_TOUCHES];
  logic [15:0]            sy_q  [MAX_TOUCHES];
  logic                   wr_en, wr_tag_en;
  logic [IdxW-1:0]        wr_idx;
  logic [15:0]            wr_x, wr_y;

  // pointer state
  logic [15:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [7:0]  cur_btn_q, cur_btn_d;
  logic        known_q, known_d, pend_q, pend_d, armed_q, armed_d;
  logic [15:0] rel_x_q, rel_x_d, rel_y_q, rel_y_d;

  // sequencer
  logic [2:0]      state_q, state_d;
  ttp_cmd_t        ent_q, ent_d;
  logic            hit_q, hit_d, free_ok_q, free_ok_d, force_q, force_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  logic [16:0]     ax_q, ax_d, ay_q, ay_d;
  ttp_res_t        res_q [2];
  ttp_res_t        res_d [2];
  logic [1:0]      res_cnt_q, res_cnt_d;
  logic            emit_ptr_q, emit_ptr_d;

  // output register
  ttp_res_t out_q, out_d;
  logic     out_last_q, out_last_d, out_valid_q, out_valid_d;

  // lookups
  logic            lk_hit, lk_free_ok;
  logic [IdxW-1:0] lk_hit_idx, lk_free_idx;
  logic            first_ok, second_ok;
  logic [IdxW-1:0] first_idx, second_idx, rd_idx;
  logic [15:0]     rd_x, rd_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= 8'd1;
      right_q <= 8'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LEFT:  left_q  <= cfg_data_i;
        REG_RIGHT: right_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // tag match and free slot, one comparator per slot on the queue head
  always_comb begin
    lk_hit      = 1'b0;
    lk_free_ok  = 1'b0;
    lk_hit_idx  = '0;
    lk_free_idx = '0;
    for (int i = 0; i < MAX_TOUCHES; i++) begin
      if (!lk_hit && used_q[i] && (tag_q[i] == q_stat_i.head.tag)) begin
        lk_hit     = 1'b1;
        lk_hit_idx = IdxW'(i);
      end
      if (!lk_free_ok && !used_q[i]) begin
        lk_free_ok  = 1'b1;
        lk_free_idx = IdxW'(i);
      end
    end
  end

  // two lowest used slots
  always_comb begin
    first_ok   = 1'b0;
    second_ok  = 1'b0;
    first_idx  = '0;
    second_idx = '0;
    for (int i = 0; i < MAX_TOUCHES; i++) begin
      if (used_q[i]) begin
        if (!first_ok) begin
          first_ok  = 1'b1;
          first_idx = IdxW'(i);
        end else if (!second_ok) begin
          second_ok  = 1'b1;
          second_idx = IdxW'(i);
        end
      end
    end
  end

  // single read port on the slot coordinates
  always_comb begin
    unique case (state_q)
      ST_PICK_A: rd_idx = first_idx;
      ST_PICK_B: rd_idx = second_idx;
      default:   rd_idx = hit_idx_q;
    endcase
    rd_x = sx_q[rd_idx];
    rd_y = sy_q[rd_idx];
  end

  always_comb begin
    logic [MAX_TOUCHES-1:0] remaining;
    logic [15:0]            rx, ry, nx, ny;
    logic [7:0]             nb;
    logic [16:0]            sum_x, sum_y, mid_x, mid_y;
    logic                   suppress;

    state_d     = state_q;
    ent_d       = ent_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    free_ok_d   = free_ok_q;
    free_idx_d  = free_idx_q;
    force_d     = force_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    res_d       = res_q;
    res_cnt_d   = res_cnt_q;
    emit_ptr_d  = emit_ptr_q;
    used_d      = used_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    cur_btn_d   = cur_btn_q;
    known_d     = known_q;
    pend_d      = pend_q;
    armed_d     = armed_q;
    rel_x_d     = rel_x_q;
    rel_y_d     = rel_y_q;
    wr_en       = 1'b0;
    wr_tag_en   = 1'b0;
    wr_idx      = hit_idx_q;
    wr_x        = ent_q.x;
    wr_y        = ent_q.y;
    q_pop_o     = 1'b0;
    out_d       = out_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q & ~res_ready_i;

    remaining = used_q & ~(MAX_TOUCHES'(1) << hit_idx_q);
    rx        = ent_q.inb ? ent_q.x : rd_x;
    ry        = ent_q.inb ? ent_q.y : rd_y;
    sum_x     = ax_q + {rd_x[15], rd_x};
    sum_y     = ay_q + {rd_y[15], rd_y};
    // truncate toward zero: bias negative sums by one before the shift
    mid_x     = sum_x + {16'd0, sum_x[16]};
    mid_y     = sum_y + {16'd0, sum_y[16]};
    nx        = second_ok ? mid_x[16:1] : ax_q[15:0];
    ny        = second_ok ? mid_y[16:1] : ay_q[15:0];
    nb        = second_ok ? right_q : left_q;
    suppress  = !force_q && known_q && (nx == cur_x_q) && (ny == cur_y_q) &&
                (nb == cur_btn_q);

    unique case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          q_pop_o    = 1'b1;
          ent_d      = q_stat_i.head;
          hit_d      = lk_hit;
          hit_idx_d  = lk_hit_idx;
          free_ok_d  = lk_free_ok;
          free_idx_d = lk_free_idx;
          res_cnt_d  = 2'd0;
          emit_ptr_d = 1'b0;
          state_d    = ST_APPLY;
        end
      end

      ST_APPLY: begin
        state_d = ST_EMIT;
        unique case (ent_q.op)
          OP_RESET: begin
            if (cur_btn_q != 8'd0) begin
              res_d[0]  = ptr_res(cur_x_q, cur_y_q, 8'd0);
              res_cnt_d = 2'd1;
            end
            used_d    = '0;
            cur_x_d   = 16'd0;
            cur_y_d   = 16'd0;
            cur_btn_d = 8'd0;
            known_d   = 1'b0;
            pend_d    = 1'b0;
            armed_d   = 1'b0;
            rel_x_d   = 16'd0;
            rel_y_d   = 16'd0;
          end
          OP_DOWN: begin
            if (pend_q) begin
              res_d[0]  = ptr_res(rel_x_q, rel_y_q, 8'd0);
              res_cnt_d = 2'd1;
              cur_x_d   = rel_x_q;
              cur_y_d   = rel_y_q;
              cur_btn_d = 8'd0;
              known_d   = 1'b1;
              pend_d    = 1'b0;
              armed_d   = 1'b0;
            end
            if (hit_q || free_ok_q) begin
              wr_idx         = hit_q ? hit_idx_q : free_idx_q;
              wr_en          = 1'b1;
              wr_tag_en      = 1'b1;
              used_d[wr_idx] = 1'b1;
              force_d        = 1'b1;
              state_d        = ST_PICK_A;
            end
          end
          OP_MOVE: begin
            if (hit_q) begin
              wr_en   = ent_q.inb;
              force_d = 1'b0;
              state_d = ST_PICK_A;
            end
          end
          OP_UP: begin
            if (hit_q) begin
              used_d[hit_idx_q] = 1'b0;
              if (remaining == '0) begin
                // last finger lifted: hold the release for the frame ticks
                if (cur_btn_q != 8'd0) begin
                  pend_d  = 1'b1;
                  armed_d = 1'b0;
                  rel_x_d = rx;
                  rel_y_d = ry;
                  cur_x_d = rx;
                  cur_y_d = ry;
                  known_d = 1'b1;
                end
              end else begin
                force_d = 1'b1;
                state_d = ST_PICK_A;
              end
            end
          end
          OP_SEC: begin
            if (used_q == '0 && !pend_q) begin
              res_d[0]  = ptr_res(ent_q.x, ent_q.y, right_q);
              res_d[1]  = ptr_res(ent_q.x, ent_q.y, 8'd0);
              res_cnt_d = 2'd2;
            end
          end
          OP_MOUSE: begin
            if (used_q == '0 && !pend_q) begin
              res_d[0]  = ptr_res(ent_q.x, ent_q.y, ent_q.mbtn);
              res_cnt_d = 2'd1;
              cur_x_d   = ent_q.x;
              cur_y_d   = ent_q.y;
              cur_btn_d = ent_q.mbtn;
              known_d   = 1'b1;
              if (ent_q.wx != 8'd0 || ent_q.wy != 8'd0) begin
                res_d[1]  = wheel_res(ent_q.wx, ent_q.wy);
                res_cnt_d = 2'd2;
              end
            end
          end
          OP_FRAME: begin
            if (pend_q) begin
              if (armed_q) begin
                res_d[0]  = ptr_res(rel_x_q, rel_y_q, 8'd0);
                res_cnt_d = 2'd1;
                cur_x_d   = rel_x_q;
                cur_y_d   = rel_y_q;
                cur_btn_d = 8'd0;
                known_d   = 1'b1;
                pend_d    = 1'b0;
                armed_d   = 1'b0;
              end else begin
                armed_d = 1'b1;
              end
            end else if (used_q != '0) begin
              force_d = 1'b1;
              state_d = ST_PICK_A;
            end
          end
          default: ;
        endcase
      end

      ST_PICK_A: begin
        ax_d    = {rd_x[15], rd_x};
        ay_d    = {rd_y[15], rd_y};
        state_d = ST_PICK_B;
      end

      ST_PICK_B: begin
        if (!suppress) begin
          res_d[res_cnt_q[0]] = ptr_res(nx, ny, nb);
          res_cnt_d           = res_cnt_q + 2'd1;
          cur_x_d             = nx;
          cur_y_d             = ny;
          cur_btn_d           = nb;
          known_d             = 1'b1;
        end
        state_d = ST_EMIT;
      end

      ST_EMIT: begin
        if (res_cnt_q == 2'd0) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || res_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q[emit_ptr_q];
          out_last_d  = ({1'b0, emit_ptr_q} + 2'd1 == res_cnt_q);
          if ({1'b0, emit_ptr_q} + 2'd1 == res_cnt_q) begin
            emit_ptr_d = 1'b0;
            state_d    = ST_IDLE;
          end else begin
            emit_ptr_d = 1'b1;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      cur_x_q     <= 16'd0;
      cur_y_q     <= 16'd0;
      cur_btn_q   <= 8'd0;
      known_q     <= 1'b0;
      pend_q      <= 1'b0;
      armed_q     <= 1'b0;
      rel_x_q     <= 16'd0;
      rel_y_q     <= 16'd0;
      res_cnt_q   <= 2'd0;
      emit_ptr_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      cur_btn_q   <= cur_btn_d;
      known_q     <= known_d;
      pend_q      <= pend_d;
      armed_q     <= armed_d;
      rel_x_q     <= rel_x_d;
      rel_y_q     <= rel_y_d;
      res_cnt_q   <= res_cnt_d;
      emit_ptr_q  <= emit_ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, only read where qualified by valid state
  always_ff @(posedge clk_i) begin
    ent_q      <= ent_d;
    hit_q      <= hit_d;
    hit_idx_q  <= hit_idx_d;
    free_ok_q  <= free_ok_d;
    free_idx_q <= free_idx_d;
    force_q    <= force_d;
    ax_q       <= ax_d;
    ay_q       <= ay_d;
    res_q      <= res_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
    if (wr_en) begin
      sx_q[wr_idx] <= wr_x;
      sy_q[wr_idx] <= wr_y;
    end
    if (wr_tag_en) tag_q[wr_idx] <= ent_q.tag;
  end

  assign res_o       = out_q;
  assign res_last_o  = out_last_q;
  assign res_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_res_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_q != 2'd3)
    else $error("result count overflow");

  a_pend_no_touch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (used_q == '0))
    else $error("release pending while touches active");

  a_armed_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |-> pend_q)
    else $error("release armed without pending release");

  a_pick_touch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PICK_A || state_q == ST_PICK_B) |-> first_ok)
    else $error("pointer pick with empty touch table");
`endif

endmodule

// File: tb/touch_to_pointer_translator_core_tb.sv
// Self-checking testbench for touch_to_pointer_translator_core: directed and random
// touch, mouse and frame events, with the expected pointer actions predicted in a
// scoreboard class. Depends on ttp_pkg and the core RTL.
`timescale 1ns / 100ps

module touch_to_pointer_translator_core_tb;
  import ttp_pkg::*;

  localparam int TOUCH_SLOTS  = 4;
  localparam int DRAIN_CYCLES = 50;   // covers queue + back end of no-result events
  localparam int HOLD_CYCLES  = 400;  // long receiver hold-off
  localparam int PHASE_ITEMS  = 600;

  // command code not used by the block; must be ignored
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  localparam logic [63:0] TAG_A = 64'h8000_0000_0000_0000;
  localparam logic [63:0] TAG_B = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TAG_C = 64'h0000_0000_0000_0000;
  localparam logic [63:0] TAG_D = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TAG_E = 64'h0000_0000_0000_0001;
  localparam logic [63:0] TAG_X = 64'h0000_0000_0000_0005;  // never put down

  // one input event, command included (command seven must be representable)
  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] tag;
    logic [15:0] x;
    logic [15:0] y;
    logic        inb;
    logic [7:0]  mbtn;
    logic [7:0]  wx;
    logic [7:0]  wy;
  } touch_event_t;

  // one pointer action as seen on the output stream
  typedef struct packed {
    logic        kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  btn;
    logic [7:0]  wx;
    logic [7:0]  wy;
    logic        last;
  } pointer_action_t;

  // Tracks the touch table and pointer like the block does and keeps the
  // pointer actions still owed by the block, oldest first.
  class pointer_action_board;
    logic [7:0]         left_btn;
    logic [7:0]         right_btn;
    logic               used [TOUCH_SLOTS];
    logic [63:0]        finger [TOUCH_SLOTS];
    logic signed [15:0] sx [TOUCH_SLOTS];
    logic signed [15:0] sy [TOUCH_SLOTS];
    logic signed [15:0] cur_x;
    logic signed [15:0] cur_y;
    logic [7:0]         cur_btn;
    logic               ptr_known;
    logic               rel_pending;
    logic               rel_armed;
    logic signed [15:0] rel_x;
    logic signed [15:0] rel_y;
    pointer_action_t    owed_actions[$];
    pointer_action_t    run_actions[$];
    int                 errors;

    function new();
      left_btn  = 8'd1;
      right_btn = 8'd2;
      errors    = 0;
      clear_table();
    endfunction

    function void clear_table();
      for (int i = 0; i < TOUCH_SLOTS; i++) begin
        used[i]   = 1'b0;
        finger[i] = '0;
        sx[i]     = '0;
        sy[i]     = '0;
      end
      cur_x       = '0;
      cur_y       = '0;
      cur_btn     = '0;
      ptr_known   = 1'b0;
      rel_pending = 1'b0;
      rel_armed   = 1'b0;
      rel_x       = '0;
      rel_y       = '0;
    endfunction

    function void set_mask(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      if (idx == REG_LEFT) left_btn = val;
      else if (idx == REG_RIGHT) right_btn = val;
    endfunction

    function int outstanding();
      return owed_actions.size();
    endfunction

    function void push_action(logic kind, logic [15:0] x, logic [15:0] y, logic [7:0] btn,
                              logic [7:0] wx, logic [7:0] wy);
      pointer_action_t a;
      a.kind = kind;
      a.x    = x;
      a.y    = y;
      a.btn  = btn;
      a.wx   = wx;
      a.wy   = wy;
      a.last = 1'b0;
      run_actions.insert(run_actions.size(), a);
    endfunction

    // pointer state; a non-forced repeat of the current state is dropped
    function void emit_pointer(logic signed [15:0] x, logic signed [15:0] y, logic [7:0] btn,
                               bit force_it);
      if (!force_it && ptr_known && x == cur_x && y == cur_y && btn == cur_btn) return;
      cur_x     = x;
      cur_y     = y;
      cur_btn   = btn;
      ptr_known = 1'b1;
      push_action(KIND_PTR, x, y, btn, 8'd0, 8'd0);
    endfunction

    function int count_active();
      int n;
      n = 0;
      for (int i = 0; i < TOUCH_SLOTS; i++) if (used[i]) n++;
      return n;
    endfunction

    // pointer derived from the touch table: lowest slot, or midpoint of two lowest
    function void emit_touch_state(bit force_it);
      int n, a, b, mx, my;
      n = 0;
      a = 0;
      b = 0;
      for (int i = 0; i < TOUCH_SLOTS; i++) begin
        if (used[i]) begin
          if (n == 0) a = i;
          else if (n == 1) b = i;
          n++;
        end
      end
      if (n == 0) begin
        emit_pointer(cur_x, cur_y, 8'd0, force_it);
      end else if (n == 1) begin
        emit_pointer(sx[a], sy[a], left_btn, force_it);
      end else begin
        // int division truncates toward zero
        mx = (int'(sx[a]) + int'(sx[b])) / 2;
        my = (int'(sy[a]) + int'(sy[b])) / 2;
        emit_pointer(16'(mx), 16'(my), right_btn, force_it);
      end
    endfunction

    function int find_finger(logic [63:0] tag);
      for (int i = 0; i < TOUCH_SLOTS; i++) if (used[i] && finger[i] == tag) return i;
      return -1;
    endfunction

    function int find_free();
      for (int i = 0; i < TOUCH_SLOTS; i++) if (!used[i]) return i;
      return -1;
    endfunction

    function void flush_release();
      emit_pointer(rel_x, rel_y, 8'd0, 1'b1);
      rel_pending = 1'b0;
      rel_armed   = 1'b0;
    endfunction

    // accepted input transfer: work out the actions it causes
    function void note_event(touch_event_t ev);
      int                 idx;
      logic signed [15:0] rx, ry;
      run_actions.delete();
      case (ev.cmd)
        CMD_RESET: begin
          if (cur_btn != 0) push_action(KIND_PTR, cur_x, cur_y, 8'd0, 8'd0, 8'd0);
          clear_table();
        end
        CMD_DOWN: begin
          if (ev.inb) begin
            if (rel_pending) flush_release();
            idx = find_finger(ev.tag);
            if (idx < 0) idx = find_free();
            if (idx >= 0) begin
              used[idx]   = 1'b1;
              finger[idx] = ev.tag;
              sx[idx]     = ev.x;
              sy[idx]     = ev.y;
              emit_touch_state(1'b1);
            end
          end
        end
        CMD_MOVE: begin
          idx = find_finger(ev.tag);
          if (idx >= 0) begin
            if (ev.inb) begin
              sx[idx] = ev.x;
              sy[idx] = ev.y;
            end
            emit_touch_state(1'b0);
          end
        end
        CMD_UP: begin
          idx = find_finger(ev.tag);
          if (idx >= 0) begin
            if (ev.inb) begin
              sx[idx] = ev.x;
              sy[idx] = ev.y;
            end
            rx          = sx[idx];
            ry          = sy[idx];
            used[idx]   = 1'b0;
            finger[idx] = '0;
            sx[idx]     = '0;
            sy[idx]     = '0;
            if (count_active() == 0) begin
              // last finger lifted: release waits for the second frame tick
              if (cur_btn != 0) begin
                rel_pending = 1'b1;
                rel_armed   = 1'b0;
                rel_x       = rx;
                rel_y       = ry;
                cur_x       = rx;
                cur_y       = ry;
                ptr_known   = 1'b1;
              end
            end else begin
              emit_touch_state(1'b1);
            end
          end
        end
        CMD_SEC: begin
          if (count_active() == 0 && !rel_pending) begin
            push_action(KIND_PTR, ev.x, ev.y, right_btn, 8'd0, 8'd0);
            push_action(KIND_PTR, ev.x, ev.y, 8'd0, 8'd0, 8'd0);
          end
        end
        CMD_MOUSE: begin
          if (count_active() == 0 && !rel_pending) begin
            emit_pointer(ev.x, ev.y, ev.mbtn, 1'b1);
            if (ev.wx != 0 || ev.wy != 0)
              push_action(KIND_WHEEL, 16'd0, 16'd0, 8'd0, ev.wx, ev.wy);
          end
        end
        CMD_FRAME: begin
          if (rel_pending) begin
            if (rel_armed) flush_release();
            else rel_armed = 1'b1;
          end else if (count_active() > 0) begin
            emit_touch_state(1'b1);
          end
        end
        default: ;
      endcase
      if (run_actions.size() > 0) run_actions[run_actions.size()-1].last = 1'b1;
      foreach (run_actions[i]) owed_actions.insert(owed_actions.size(), run_actions[i]);
    endfunction

    // accepted output transfer: compare against the oldest owed action
    function void check_action(pointer_action_t got);
      pointer_action_t want;
      if (owed_actions.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected action: kind=%0d x=%0d y=%0d btn=%02h wx=%0d wy=%0d last=%0d",
                   got.kind, $signed(got.x), $signed(got.y), got.btn, $signed(got.wx),
                   $signed(got.wy), got.last);
        return;
      end
      want = owed_actions[0];
      owed_actions.delete(0);
      if (got.kind !== want.kind || got.x !== want.x || got.y !== want.y ||
          got.btn !== want.btn || got.wx !== want.wx || got.wy !== want.wy ||
          got.last !== want.last) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: exp kind=%0d x=%0d y=%0d btn=%02h wx=%0d wy=%0d last=%0d",
                   want.kind, $signed(want.x), $signed(want.y), want.btn, $signed(want.wx),
                   $signed(want.wy), want.last);
          $display("          got kind=%0d x=%0d y=%0d btn=%02h wx=%0d wy=%0d last=%0d",
                   got.kind, $signed(got.x), $signed(got.y), got.btn, $signed(got.wx),
                   $signed(got.wy), got.last);
        end
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // clock, reset and DUT signals; every input has a known value from time zero
  // ---------------------------------------------------------------------------
  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i       = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i      = '0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i  = '0;
  logic [CMD_W-1:0]       s_axis_tuser_i  = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tuser_o;
  logic                   m_axis_tlast_o;

  always #10 clk_i = ~clk_i;

  touch_to_pointer_translator_core #(
    .MAX_TOUCHES(TOUCH_SLOTS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),  // finger_tag, pos_x, pos_y, in_bounds,
                                        // mouse_buttons, scroll_x, scroll_y
    .s_axis_tuser_i  (s_axis_tuser_i),  // command
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),  // out_x, out_y, out_buttons,
                                        // out_wheel_x, out_wheel_y
    .m_axis_tuser_o  (m_axis_tuser_o),  // action_kind
    .m_axis_tlast_o  (m_axis_tlast_o)   // last_of_run
  );

  pointer_action_board board;

  // idle percentages per side, changed only between phases
  int src_idle_pct = 0;
  int snk_idle_pct = 0;

  // receiver hold-off: main flow toggles hold_req, receiver acknowledges and
  // counts the stretch down itself
  logic hold_req  = 1'b0;
  logic hold_ack  = 1'b0;
  int   hold_left = 0;

  int   events_sent = 0;
  logic [63:0] tag_pool [6];
  logic [15:0] prev_x = '0;
  logic [15:0] prev_y = '0;

  // ---------------------------------------------------------------------------
  // receiver: random tready, or held low for a long stretch on request
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_left = HOLD_CYCLES;
      hold_ack <= hold_req;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // output monitor: handshake sampled at the falling edge, where nothing moves,
  // and the transfer checked at the rising edge that completes it
  // ---------------------------------------------------------------------------
  logic            out_fire = 1'b0;
  pointer_action_t out_act;

  always @(negedge clk_i) begin
    out_fire = rst_ni && m_axis_tvalid_o && m_axis_tready_i;
    out_act.kind = m_axis_tuser_o;
    out_act.x    = m_axis_tdata_o[15:0];
    out_act.y    = m_axis_tdata_o[31:16];
    out_act.btn  = m_axis_tdata_o[39:32];
    out_act.wx   = m_axis_tdata_o[47:40];
    out_act.wy   = m_axis_tdata_o[55:48];
    out_act.last = m_axis_tlast_o;
  end

  always @(posedge clk_i) begin
    if (out_fire) board.check_action(out_act);
  end

  // ---------------------------------------------------------------------------
  // drivers; each task is entered right after a rising edge
  // ---------------------------------------------------------------------------

  // one input transfer; tvalid stays high into the next event when there is no gap
  task automatic drive_event(input logic [2:0] cmd, input logic [63:0] tag,
                             input logic [15:0] x, input logic [15:0] y, input logic inb,
                             input logic [7:0] mbtn, input logic [7:0] wx,
                             input logic [7:0] wy);
    touch_event_t ev;
    bit           taken;
    ev = '{cmd: cmd, tag: tag, x: x, y: y, inb: inb, mbtn: mbtn, wx: wx, wy: wy};
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {7'd0, wy, wx, mbtn, inb, y, x, tag};
    do begin
      @(negedge clk_i);
      taken = s_axis_tready_o;
      @(posedge clk_i);
    end while (!taken);
    board.note_event(ev);
    events_sent++;
    prev_x = x;
    prev_y = y;
  endtask

  // drop tvalid, wait until every owed action has arrived, then let the
  // back end run dry so that events with no action are finished too
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (board.outstanding() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // register write; the caller must call it only after settle() or reset, the task does not enforce it
  task automatic write_mask(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_mask(idx, val);
    @(posedge clk_i);
  endtask

  // coordinates: full range, a small cluster, or a repeat of the last one
  // (repeats make moves that must be suppressed)
  function automatic logic [15:0] pick_x();
    case ($urandom_range(3))
      0, 1:    return 16'($urandom);
      2:       return 16'($urandom_range(200) - 100);
      default: return prev_x;
    endcase
  endfunction

  function automatic logic [15:0] pick_y();
    case ($urandom_range(3))
      0, 1:    return 16'($urandom);
      2:       return 16'($urandom_range(200) - 100);
      default: return prev_y;
    endcase
  endfunction

  function automatic logic [63:0] rand_tag();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [7:0] rand_wheel();
    return ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom);
  endfunction

  // touch sequence: fingers down, moves, frame ticks, further downs and ups, all up,
  // then up to three ticks, which flush the pending release when there are two or more
  task automatic touch_gesture();
    logic [63:0] held[$];
    int          n_down;
    int          k;
    logic [63:0] t;
    n_down = $urandom_range(1, 5);
    repeat (n_down) begin
      t = tag_pool[$urandom_range(5)];
      drive_event(CMD_DOWN, t, pick_x(), pick_y(), $urandom_range(19) != 0, 8'($urandom),
                  8'($urandom), 8'($urandom));
      held.insert(held.size(), t);
    end
    repeat ($urandom_range(0, 10)) begin
      case ($urandom_range(9))
        6, 7: drive_event(CMD_FRAME, rand_tag(), 16'($urandom), 16'($urandom), 1'($urandom),
                          8'($urandom), 8'($urandom), 8'($urandom));
        8: begin
          t = tag_pool[$urandom_range(5)];
          drive_event(CMD_DOWN, t, pick_x(), pick_y(), 1'b1, 8'($urandom), 8'($urandom),
                      8'($urandom));
          held.insert(held.size(), t);
        end
        9: begin
          if (held.size() > 0) begin
            k = $urandom_range(held.size() - 1);
            drive_event(CMD_UP, held[k], pick_x(), pick_y(), 1'($urandom), 8'($urandom),
                        8'($urandom), 8'($urandom));
            held.delete(k);
          end
        end
        default: begin
          t = (held.size() > 0) ? held[$urandom_range(held.size() - 1)] : rand_tag();
          drive_event(CMD_MOVE, t, pick_x(), pick_y(), $urandom_range(9) != 0, 8'($urandom),
                      8'($urandom), 8'($urandom));
        end
      endcase
    end
    while (held.size() > 0) begin
      k = $urandom_range(held.size() - 1);
      drive_event(CMD_UP, held[k], pick_x(), pick_y(), $urandom_range(4) != 0, 8'($urandom),
                  8'($urandom), 8'($urandom));
      held.delete(k);
    end
    repeat ($urandom_range(0, 3))
      drive_event(CMD_FRAME, rand_tag(), 16'($urandom), 16'($urandom), 1'($urandom),
                  8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // random phase: half gestures, the rest mouse, clicks, ticks and raw noise
  task automatic random_phase(input int n_items, input int hold_at);
    int       start;
    bit       hold_done;
    int       pick;
    logic [2:0] cmd;
    start     = events_sent;
    hold_done = (hold_at < 0);
    while (events_sent - start < n_items) begin
      if (!hold_done && events_sent - start >= hold_at) begin
        hold_req <= ~hold_req;
        hold_done = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 50) begin
        touch_gesture();
      end else if (pick < 70) begin
        repeat ($urandom_range(1, 4))
          drive_event(CMD_MOUSE, rand_tag(), pick_x(), pick_y(), 1'($urandom), 8'($urandom),
                      rand_wheel(), rand_wheel());
      end else if (pick < 80) begin
        drive_event(CMD_SEC, rand_tag(), pick_x(), pick_y(), 1'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom));
      end else if (pick < 85) begin
        drive_event(CMD_FRAME, rand_tag(), 16'($urandom), 16'($urandom), 1'($urandom),
                    8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        // noise: any command with any content, resets kept rare
        cmd = 3'($urandom_range(7));
        if (cmd == CMD_RESET && $urandom_range(3) != 0) cmd = CMD_FRAME;
        drive_event(cmd, ($urandom_range(1) == 0) ? rand_tag() : tag_pool[$urandom_range(5)],
                    16'($urandom), 16'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    board = new();
    foreach (tag_pool[i]) tag_pool[i] = rand_tag();
    tag_pool[0] = TAG_C;
    tag_pool[1] = TAG_D;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, default button codes written back explicitly
    src_idle_pct = 20;
    snk_idle_pct = 64;
    write_mask(REG_LEFT, 8'h01);
    write_mask(REG_RIGHT, 8'h02);

    // mouse at the coordinate extremes, with wheel on both axes, none, one axis
    drive_event(CMD_MOUSE, '1, 16'h8000, 16'h7FFF, 1'b1, 8'hFF, 8'h80, 8'h7F);
    drive_event(CMD_MOUSE, '0, 16'h0000, 16'h0000, 1'b0, 8'h00, 8'h00, 8'h00);
    drive_event(CMD_MOUSE, '0, 16'h7FFF, 16'h8000, 1'b0, 8'h00, 8'h00, 8'h01);
    // secondary click: press then release, pointer state untouched
    drive_event(CMD_SEC, '1, 16'h7FFF, 16'h8000, 1'b1, 8'hFF, 8'hFF, 8'hFF);
    // finger down outside the screen is dropped
    drive_event(CMD_DOWN, TAG_A, 16'd100, 16'd200, 1'b0, 8'h00, 8'h00, 8'h00);
    drive_event(CMD_DOWN, TAG_A, -16'sd3, -16'sd5, 1'b1, 8'h00, 8'h00, 8'h00);
    // mouse and secondary click are ignored while a touch is active
    drive_event(CMD_MOUSE, '0, 16'd1, 16'd1, 1'b1, 8'h04, 8'h01, 8'h01);
    drive_event(CMD_SEC, '0, 16'd1, 16'd1, 1'b1, 8'h00, 8'h00, 8'h00);
    // move of an unknown finger, move to the same spot, move outside the screen
    drive_event(CMD_MOVE, TAG_X, 16'd7, 16'd7, 1'b1, 8'h00, 8'h00, 8'h00);
    drive_event(CMD_MOVE, TAG_A, -16'sd3, -16'sd5, 1'b1, 8'h00, 8'h00, 8'h00);
    drive_event(CMD_MOVE, TAG_A, 16'd999, 16'd999, 1'b0, 8'h00, 8'h00, 8'h00);
    // second finger: right button at a negative midpoint truncated toward zero
    drive_event(CMD_DOWN, TAG_B, 16'd0, 16'd0, 1'b1, 8'h00, 8'h00, 8'h00);
    drive_event(CMD_DOWN, TAG_C, 16'h7FFF, 16'h7FFF, 1'b1, 8'h00, 8'h00, 8'h00);
    drive_event(CMD_DOWN, TAG_D, 16'h8000, 16'h8000, 1'b1, 8'h00, 8'h00, 8'h00);
    // table full: the fifth finger is lost
    drive_event(CMD_DOWN, TAG_E, 16'd5, 16'd5, 1'b1, 8'h00, 8'h00, 8'h00);
    // down again on a known finger updates its slot
    drive_event(CMD_DOWN, TAG_B, 16'h8000, 16'h8000, 1'b1, 8'h00, 8'h00, 8'h00);
    drive_event(CMD_FRAME, '0, 16'd0, 16'd0, 1'b0, 8'h00, 8'h00, 8'h00);
    drive_event(CMD_UP, TAG_A, 16'd10, 16'd10, 1'b1, 8'h00, 8'h00, 8'h00);
    drive_event(CMD_UP, TAG_X, 16'd10, 16'd10, 1'b1, 8'h00, 8'h00, 8'h00);
    drive_event(CMD_UP, TAG_B, 16'd20, 16'd20, 1'b1, 8'h00, 8'h00, 8'h00);
    drive_event(CMD_UP, TAG_C, 16'd30, 16'd30, 1'b0, 8'h00, 8'h00, 8'h00);
    // last finger up: release pending, mouse ignored, emitted on the second tick
    drive_event(CMD_UP, TAG_D, 16'd40, 16'd40, 1'b1, 8'h00, 8'h00, 8'h00);
    drive_event(CMD_MOUSE, '0, 16'd2, 16'd2, 1'b1, 8'h01, 8'h00, 8'h00);
    drive_event(CMD_FRAME, '0, 16'd0, 16'd0, 1'b0, 8'h00, 8'h00, 8'h00);
    drive_event(CMD_FRAME, '0, 16'd0, 16'd0, 1'b0, 8'h00, 8'h00, 8'h00);
    // a new touch flushes a pending release before its own press
    drive_event(CMD_DOWN, TAG_A, 16'd1, 16'd1, 1'b1, 8'h00, 8'h00, 8'h00);
    drive_event(CMD_UP, TAG_A, 16'd1, 16'd1, 1'b1, 8'h00, 8'h00, 8'h00);
    drive_event(CMD_DOWN, TAG_B, 16'd2, 16'd2, 1'b1, 8'h00, 8'h00, 8'h00);
    // reset command with a button held, then with none
    drive_event(CMD_RESET, '0, 16'd0, 16'd0, 1'b0, 8'h00, 8'h00, 8'h00);
    drive_event(CMD_RESET, '0, 16'd0, 16'd0, 1'b0, 8'h00, 8'h00, 8'h00);
    drive_event(CMD_UNUSED, '1, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF, 8'hFF, 8'hFF);
    settle();

    // sender idles less than the receiver; one long receiver hold-off
    write_mask(REG_LEFT, 8'hFF);
    write_mask(REG_RIGHT, 8'h00);
    random_phase(PHASE_ITEMS, 150);
    settle();

    // the other way round
    src_idle_pct = 64;
    snk_idle_pct = 20;
    write_mask(REG_LEFT, 8'h00);
    write_mask(REG_RIGHT, 8'hFF);
    random_phase(PHASE_ITEMS, -1);
    settle();

    // back to back on both sides
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_mask(REG_LEFT, 8'($urandom_range(1, 254)));
    write_mask(REG_RIGHT, 8'($urandom_range(1, 254)));
    random_phase(PHASE_ITEMS, -1);
    settle();

    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(20_000_000);
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: touch_to_pointer_translator_core.f
hdl/ttp_pkg.sv
hdl/ttp_front.sv
hdl/ttp_queue.sv
hdl/ttp_back.sv
hdl/touch_to_pointer_translator_core.sv
tb/touch_to_pointer_translator_core_tb.sv
